[design/lru_cache_set_update_top_assert.svh]
// assertion macros for the lru cache set checker
// depends on nothing; included by the checker file
`ifndef LRU_CACHE_SET_UPDATE_TOP_ASSERT_SVH
`define LRU_CACHE_SET_UPDATE_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LCSU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru cache set check failed");

// next-cycle implication, disabled in reset
`define LCSU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru cache set check failed");

`endif

[design/lcsu_pkg.sv]
// shared types and constants for the lru cache set update block
// depends on nothing
package lcsu_pkg;

  // width of the associativity register and of the occupancy field
  localparam int WAYS_BITS = 4;
  localparam int OCC_BITS  = 4;

  // associativity after reset
  localparam logic [WAYS_BITS-1:0] WAYS_RESET = 4'd8;

  // status of one access, from the set store to the result register
  typedef struct packed {
    logic                hit;
    logic                evicted;
    logic [OCC_BITS-1:0] occupancy;
  } lcsu_result_t;

endpackage

[design/lcsu_set.sv]
// tag store of one cache set in recency order, with compare and update logic
// depends on lcsu_pkg
module lcsu_set #(
  parameter int MAX_WAYS = 8,
  parameter int TAG_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [TAG_BITS-1:0]            tag,
  input  logic [lcsu_pkg::WAYS_BITS-1:0] ways_in_use,
  output lcsu_pkg::lcsu_result_t         result,
  output logic [TAG_BITS-1:0]            evicted_tag
);
  import lcsu_pkg::*;

  localparam int IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  // wide enough for way numbers and MAX_WAYS itself
  localparam int CMP_W = 6;

  logic [TAG_BITS-1:0] tags [MAX_WAYS];
  logic [OCC_BITS-1:0] count;
  logic [OCC_BITS-1:0] count_next;

  logic             found;
  logic [IDX_W-1:0] pos;
  logic [CMP_W-1:0] count6;
  logic [CMP_W-1:0] eff6;
  logic [CMP_W-1:0] upto6;
  logic             full;
  logic             ev;

  // parallel compare over valid ways, lowest matching way wins
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if ((CMP_W'(i) < count6) && (tags[i] == tag)) begin
        found = 1'b1;
        pos   = IDX_W'(i);
      end
    end
  end

  // effective associativity: zero acts as one, clamp at the store depth
  always_comb begin
    eff6 = CMP_W'(ways_in_use);
    if (ways_in_use == '0) begin
      eff6 = CMP_W'(1);
    end
    if (eff6 > CMP_W'(MAX_WAYS)) begin
      eff6 = CMP_W'(MAX_WAYS);
    end
  end

  // shift range, eviction and new occupancy
  always_comb begin
    count6 = CMP_W'(count);
    full   = (count6 >= eff6);
    ev     = !found && full;
    if (found) begin
      upto6 = CMP_W'(pos);
    end else if (full) begin
      upto6 = count6 - CMP_W'(1);
    end else begin
      upto6 = count6;
    end
    count_next = (!found && !full) ? count + OCC_BITS'(1) : count;
  end

  assign evicted_tag      = ev ? tags[upto6[IDX_W-1:0]] : '0;
  assign result.hit       = found;
  assign result.evicted   = ev;
  assign result.occupancy = count_next;

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (en) begin
      count <= count_next;
    end
  end

  // move ways toward the lru end and put the tag at the front
  always_ff @(posedge clk) begin
    if (en) begin
      tags[0] <= tag;
      for (int i = 1; i < MAX_WAYS; i++) begin
        if (CMP_W'(i) <= upto6) begin
          tags[i] <= tags[i-1];
        end
      end
    end
  end

endmodule

[design/lru_cache_set_update_top.sv]
// channel   dir  signals                                       accepted when
// request   in   in_valid in_ready lookup_tag                  in_valid & in_ready
// result    out  out_valid out_ready hit evicted               out_valid & out_ready
//                evicted_tag occupancy
// config    in   cfg_valid cfg_ready cfg_data (ways_in_use)    cfg_valid & cfg_ready
//
// one request per cycle unless the result stalls: a request is held in the input
// register, then the set store is compared and updated in one pass and the result
// register is loaded.
// reset empties the set and sets the associativity to eight; no clearing pass.
// a stalled result register holds the input register, and in_ready follows.
// top level of the lru cache set update block; depends on lcsu_pkg and lcsu_set
module lru_cache_set_update_top #(
  parameter int MAX_WAYS = 8,
  parameter int TAG_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [TAG_BITS-1:0]            lookup_tag,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic                           evicted,
  output logic [TAG_BITS-1:0]            evicted_tag,
  output logic [lcsu_pkg::OCC_BITS-1:0]  occupancy,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lcsu_pkg::WAYS_BITS-1:0] cfg_data
);
  import lcsu_pkg::*;

  logic [WAYS_BITS-1:0] ways_reg;
  logic                 s1_valid;
  logic [TAG_BITS-1:0]  s1_tag;
  logic                 advance;
  lcsu_result_t         set_result;
  logic [TAG_BITS-1:0]  set_evicted_tag;

  // handshake: input register moves when the result register is free
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  // associativity register
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_reg <= WAYS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ways_reg <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_tag <= lookup_tag;
    end
  end

  // set store and update
  lcsu_set #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_set (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .tag         (s1_tag),
    .ways_in_use (ways_reg),
    .result      (set_result),
    .evicted_tag (set_evicted_tag)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit         <= set_result.hit;
      evicted     <= set_result.evicted;
      occupancy   <= set_result.occupancy;
      evicted_tag <= set_evicted_tag;
    end
  end

endmodule

[design/lcsu_checker.sv]
// port-level checks for the lru cache set update block, bound to the top level
// depends on lcsu_pkg and lru_cache_set_update_top_assert.svh
`include "lru_cache_set_update_top_assert.svh"

module lcsu_checker #(
  parameter int TAG_BITS = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input logic                          evicted,
  input logic [TAG_BITS-1:0]           evicted_tag,
  input logic [lcsu_pkg::OCC_BITS-1:0] occupancy
);
  import lcsu_pkg::*;

  // a stalled result keeps its payload
  `LCSU_ASSERT_NXT(a_out_hold, clk, rst, !rst && out_valid && !out_ready, out_valid && $stable(hit) && $stable(evicted) && $stable(evicted_tag) && $stable(occupancy))

  // a hit never evicts
  `LCSU_ASSERT_IMP(a_hit_no_evict, clk, rst, out_valid && hit, !evicted)

  // no eviction reports a zero tag
  `LCSU_ASSERT_IMP(a_tag_zero, clk, rst, out_valid && !evicted, evicted_tag == '0)

  // after any access the set holds at least that tag
  `LCSU_ASSERT_IMP(a_occ_nonzero, clk, rst, out_valid, occupancy != '0)

endmodule

bind lru_cache_set_update_top lcsu_checker #(
  .TAG_BITS (TAG_BITS)
) u_lcsu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .hit         (hit),
  .evicted     (evicted),
  .evicted_tag (evicted_tag),
  .occupancy   (occupancy)
);
